/* src/thac_pkg.sv */
package thac_pkg;

	// input sample width
	localparam int IN_W = 16;

	// parameter defaults
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int CORDIC_STAGES_DEF   = 16;

	// angle accumulator: degrees with 22 fraction bits
	localparam int ZFRAC   = 22;
	localparam int ZW      = 32;
	localparam int TAB_LEN = 24;

	// datapath widths
	localparam int NQ_W   = 32;   // floor(|a| * 2^16)
	localparam int Q_W    = 17;   // Q16 cosine magnitude, up to 1.0
	localparam int C_W    = 18;   // signed Q16 cosine
	localparam int CW     = 53;   // CORDIC x/y width
	localparam int TILT_W = 15;
	localparam int HEAD_W = 16;

	// side data that rides along the norm root and the divider
	typedef struct packed {
		logic [IN_W-1:0]        mag_r;
		logic [IN_W-1:0]        mag_p;
		logic [IN_W-1:0]        mag_v;
		logic                   neg_r;
		logic                   neg_p;
		logic                   neg_v;
		logic signed [IN_W-1:0] mx;
		logic signed [IN_W-1:0] my;
		logic signed [IN_W-1:0] mz;
		logic                   inv;
	} norm_side_t;

	// side data that rides along the sine roots
	typedef struct packed {
		logic signed [C_W-1:0]  cr;
		logic signed [C_W-1:0]  cp;
		logic signed [C_W-1:0]  cv;
		logic signed [IN_W-1:0] mx;
		logic signed [IN_W-1:0] my;
		logic signed [IN_W-1:0] mz;
		logic                   inv;
	} sine_side_t;

	// atan(2^-i) in degrees, 22 fraction bits
	function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = 32'sd188743680;
			1:  r = 32'sd111421900;
			2:  r = 32'sd58872272;
			3:  r = 32'sd29884485;
			4:  r = 32'sd15000234;
			5:  r = 32'sd7507429;
			6:  r = 32'sd3754631;
			7:  r = 32'sd1877430;
			8:  r = 32'sd938729;
			9:  r = 32'sd469366;
			10: r = 32'sd234683;
			11: r = 32'sd117342;
			12: r = 32'sd58671;
			13: r = 32'sd29335;
			14: r = 32'sd14668;
			15: r = 32'sd7334;
			16: r = 32'sd3667;
			17: r = 32'sd1833;
			18: r = 32'sd917;
			19: r = 32'sd458;
			20: r = 32'sd229;
			21: r = 32'sd115;
			22: r = 32'sd57;
			23: r = 32'sd29;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/thac_root.sv */
// Pipelined digit-by-digit integer square root, one result bit per stage.
module thac_root #(
	parameter int RW    = 32,
	parameter int LANES = 1,
	parameter int TAG_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [LANES-1:0][2*RW-1:0]     radicand,
	input  logic [TAG_W-1:0]               in_tag,
	output logic                           out_valid,
	output logic [LANES-1:0][RW-1:0]       root,
	output logic [TAG_W-1:0]               out_tag
);

	logic                         vld_s [RW];
	logic [LANES-1:0][2*RW-1:0]   rad_s [RW];
	logic [LANES-1:0][RW+1:0]     rem_s [RW];
	logic [LANES-1:0][RW-1:0]     res_s [RW];
	logic [TAG_W-1:0]             tag_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic                       vld_in;
		logic [LANES-1:0][2*RW-1:0] rad_in;
		logic [LANES-1:0][RW+1:0]   rem_in;
		logic [LANES-1:0][RW-1:0]   res_in;
		logic [TAG_W-1:0]           tag_in;
		logic [LANES-1:0][RW+1:0]   rem_nx;
		logic [LANES-1:0][RW-1:0]   res_nx;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rad_in = radicand;
			assign rem_in = '0;
			assign res_in = '0;
			assign tag_in = in_tag;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rad_in = rad_s[k-1];
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		// bring down the next bit pair and try (root << 2) | 1
		always_comb begin
			logic [RW+3:0] remx;
			logic [RW+3:0] trial;
			logic [RW+3:0] diff;
			for (int l = 0; l < LANES; l++) begin
				remx  = {rem_in[l], rad_in[l][2*(RW-1-k)+1 -: 2]};
				trial = {2'b00, res_in[l], 2'b01};
				diff  = remx - trial;
				if (remx >= trial) begin
					rem_nx[l] = diff[RW+1:0];
					res_nx[l] = {res_in[l][RW-2:0], 1'b1};
				end else begin
					rem_nx[l] = remx[RW+1:0];
					res_nx[l] = {res_in[l][RW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k] <= rad_in;
			rem_s[k] <= rem_nx;
			res_s[k] <= res_nx;
			tag_s[k] <= tag_in;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = res_s[RW-1];
	assign out_tag   = tag_s[RW-1];

endmodule

/* src/thac_cordic.sv */
// Pipelined CORDIC vectoring: atan2(y, x) in degrees, one rotation per stage.
module thac_cordic #(
	parameter int W      = 53,
	parameter int STAGES = 16,
	parameter int LANES  = 1,
	parameter int TAG_W  = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [LANES-1:0][W-1:0]             x_in,
	input  logic [LANES-1:0][W-1:0]             y_in,
	input  logic [TAG_W-1:0]                    in_tag,
	output logic                                out_valid,
	output logic [LANES-1:0][thac_pkg::ZW-1:0]  angle,
	output logic [TAG_W-1:0]                    out_tag
);
	import thac_pkg::*;

	localparam logic signed [ZW-1:0] Z180 = ZW'(64'sd180 << ZFRAC);

	logic                      vld_s  [STAGES+1];
	logic [LANES-1:0][W-1:0]   x_s    [STAGES+1];
	logic [LANES-1:0][W-1:0]   y_s    [STAGES+1];
	logic [LANES-1:0][ZW-1:0]  z_s    [STAGES+1];
	logic [LANES-1:0]          zero_s [STAGES+1];
	logic [TAG_W-1:0]          tag_s  [STAGES+1];

	// pre-rotation: fold the left half plane by +-180 degrees
	logic [LANES-1:0][W-1:0]  x_pre;
	logic [LANES-1:0][W-1:0]  y_pre;
	logic [LANES-1:0][ZW-1:0] z_pre;
	logic [LANES-1:0]         zero_pre;

	always_comb begin
		logic signed [W-1:0] xi;
		logic signed [W-1:0] yi;
		for (int l = 0; l < LANES; l++) begin
			xi          = $signed(x_in[l]);
			yi          = $signed(y_in[l]);
			zero_pre[l] = (xi == '0) && (yi == '0);
			if (xi < 0) begin
				x_pre[l] = -xi;
				y_pre[l] = -yi;
				z_pre[l] = (yi >= 0) ? Z180 : -Z180;
			end else begin
				x_pre[l] = xi;
				y_pre[l] = yi;
				z_pre[l] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= x_pre;
		y_s[0]    <= y_pre;
		z_s[0]    <= z_pre;
		zero_s[0] <= zero_pre;
		tag_s[0]  <= in_tag;
	end

	for (genvar k = 1; k <= STAGES; k++) begin : g_stage
		logic [LANES-1:0][W-1:0]  x_nx;
		logic [LANES-1:0][W-1:0]  y_nx;
		logic [LANES-1:0][ZW-1:0] z_nx;

		// micro-rotation by atan(2^-(k-1)) toward y = 0
		always_comb begin
			logic signed [W-1:0]  xc;
			logic signed [W-1:0]  yc;
			logic signed [W-1:0]  xs;
			logic signed [W-1:0]  ys;
			logic signed [ZW-1:0] zc;
			for (int l = 0; l < LANES; l++) begin
				xc = $signed(x_s[k-1][l]);
				yc = $signed(y_s[k-1][l]);
				zc = $signed(z_s[k-1][l]);
				xs = xc >>> (k-1);
				ys = yc >>> (k-1);
				if (yc >= 0) begin
					x_nx[l] = xc + ys;
					y_nx[l] = yc - xs;
					z_nx[l] = zc + atan_deg(k-1);
				end else begin
					x_nx[l] = xc - ys;
					y_nx[l] = yc + xs;
					z_nx[l] = zc - atan_deg(k-1);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			x_s[k]    <= x_nx;
			y_s[k]    <= y_nx;
			z_s[k]    <= z_nx;
			zero_s[k] <= zero_s[k-1];
			tag_s[k]  <= tag_s[k-1];
		end
	end

	// a null vector reads as zero degrees
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			angle[l] = zero_s[STAGES][l] ? '0 : z_s[STAGES][l];
		end
	end

	assign out_valid = vld_s[STAGES];
	assign out_tag   = tag_s[STAGES];

endmodule

/* src/tilt_and_heading_angles_top.sv */
// Tilt angles and tilt-compensated compass heading, fully pipelined.
// Pipeline: s1 to s3 registers, 32-stage norm root, 17-stage divider, s4,
// 17-stage sine root, s5 to s7, CORDIC_STAGES + 1 CORDIC, s8 result register.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Reset (arst_n low) clears all valid bits; requests in flight are dropped.
module tilt_and_heading_angles_top #(
	parameter int ANGLE_FRAC_BITS = thac_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = thac_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [thac_pkg::IN_W-1:0]    accel_x,
	input  logic signed [thac_pkg::IN_W-1:0]    accel_y,
	input  logic signed [thac_pkg::IN_W-1:0]    accel_z,
	input  logic signed [thac_pkg::IN_W-1:0]    mag_x,
	input  logic signed [thac_pkg::IN_W-1:0]    mag_y,
	input  logic signed [thac_pkg::IN_W-1:0]    mag_z,
	output logic                                done,
	output logic [thac_pkg::TILT_W-1:0]         roll_angle,
	output logic [thac_pkg::TILT_W-1:0]         pitch_angle,
	output logic [thac_pkg::TILT_W-1:0]         vertical_angle,
	output logic [thac_pkg::HEAD_W-1:0]         heading_angle,
	output logic                                vector_invalid
);
	import thac_pkg::*;

	localparam int SH = ZFRAC - ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] HALF = ZW'(64'sd1 << (SH - 1));
	localparam logic signed [ZW-1:0] TOP  = ZW'(64'sd180 << ANGLE_FRAC_BITS);
	localparam logic signed [ZW-1:0] FULL = ZW'(64'sd360 << ANGLE_FRAC_BITS);
	localparam logic signed [ZW-1:0] Z360 = ZW'(64'sd360 << ZFRAC);
	localparam logic [Q_W-1:0]       ONE_Q = Q_W'(1 << 16);

	assign busy = 1'b0;

	// s1: capture request
	logic                   v_s1;
	logic signed [IN_W-1:0] ax_s1, ay_s1, az_s1, mx_s1, my_s1, mz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			ax_s1 <= accel_x;
			ay_s1 <= accel_y;
			az_s1 <= accel_z;
			mx_s1 <= mag_x;
			my_s1 <= mag_y;
			mz_s1 <= mag_z;
		end
	end

	// s2: squares and component magnitudes
	logic              v_s2;
	logic [NQ_W-1:0]   sqx_s2, sqy_s2, sqz_s2;
	norm_side_t        side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2        <= NQ_W'(ax_s1) * NQ_W'(ax_s1);
		sqy_s2        <= NQ_W'(ay_s1) * NQ_W'(ay_s1);
		sqz_s2        <= NQ_W'(az_s1) * NQ_W'(az_s1);
		side_s2.mag_r <= ay_s1[IN_W-1] ? $unsigned(-ay_s1) : $unsigned(ay_s1);
		side_s2.mag_p <= ax_s1[IN_W-1] ? $unsigned(-ax_s1) : $unsigned(ax_s1);
		side_s2.mag_v <= az_s1[IN_W-1] ? $unsigned(-az_s1) : $unsigned(az_s1);
		side_s2.neg_r <= (ay_s1 > 0);
		side_s2.neg_p <= ax_s1[IN_W-1];
		side_s2.neg_v <= az_s1[IN_W-1];
		side_s2.mx    <= mx_s1;
		side_s2.my    <= my_s1;
		side_s2.mz    <= mz_s1;
		side_s2.inv   <= 1'b0;
	end

	// s3: squared norm
	logic            v_s3;
	logic [NQ_W-1:0] n2_s3;
	norm_side_t      side_s3;
	logic [NQ_W-1:0] n2_sum;
	norm_side_t      side_s3_d;

	assign n2_sum = sqx_s2 + sqy_s2 + sqz_s2;

	// flag a zero acceleration vector
	always_comb begin
		side_s3_d     = side_s2;
		side_s3_d.inv = (n2_sum == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		n2_s3   <= n2_sum;
		side_s3 <= side_s3_d;
	end

	// norm root: nq = floor(sqrt(n2 * 2^32))
	logic                     nq_valid;
	logic [0:0][NQ_W-1:0]     nq_root;
	norm_side_t               nq_side;
	logic [0:0][2*NQ_W-1:0]   nq_rad;
	norm_side_t               nq_side_in;

	assign nq_rad[0] = {n2_s3, {NQ_W{1'b0}}};
	assign nq_side_in = side_s3;

	thac_root #(
		.RW    (NQ_W),
		.LANES (1),
		.TAG_W ($bits(norm_side_t))
	) u_norm_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.radicand  (nq_rad),
		.in_tag    (nq_side_in),
		.out_valid (nq_valid),
		.root      (nq_root),
		.out_tag   (nq_side)
	);

	// divider: q = floor(|a| * 2^32 / nq), one quotient bit per stage, three lanes
	logic                      dv_s    [Q_W];
	logic [2:0][NQ_W-1:0]      drem_s  [Q_W];
	logic [2:0][Q_W-1:0]       dq_s    [Q_W];
	logic [NQ_W-1:0]           dnq_s   [Q_W];
	norm_side_t                dside_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic                 v_in;
		logic [2:0][NQ_W-1:0] rem_in;
		logic [2:0][Q_W-1:0]  q_in;
		logic [NQ_W-1:0]      nq_in;
		norm_side_t           side_in;
		logic [2:0][NQ_W-1:0] rem_nx;
		logic [2:0][Q_W-1:0]  q_nx;

		if (k == 0) begin : g_first
			assign v_in      = nq_valid;
			assign rem_in[0] = {1'b0, nq_side.mag_r, 15'b0};
			assign rem_in[1] = {1'b0, nq_side.mag_p, 15'b0};
			assign rem_in[2] = {1'b0, nq_side.mag_v, 15'b0};
			assign q_in      = '0;
			assign nq_in     = nq_root[0];
			assign side_in   = nq_side;
		end else begin : g_next
			assign v_in    = dv_s[k-1];
			assign rem_in  = drem_s[k-1];
			assign q_in    = dq_s[k-1];
			assign nq_in   = dnq_s[k-1];
			assign side_in = dside_s[k-1];
		end

		// shift in a zero dividend bit, subtract the divisor when it fits
		always_comb begin
			logic [NQ_W:0] r2;
			logic [NQ_W:0] diff;
			for (int l = 0; l < 3; l++) begin
				r2      = {rem_in[l], 1'b0};
				diff    = r2 - {1'b0, nq_in};
				q_nx[l] = q_in[l];
				if (r2 >= {1'b0, nq_in}) begin
					rem_nx[l]           = diff[NQ_W-1:0];
					q_nx[l][Q_W-1-k]    = 1'b1;
				end else begin
					rem_nx[l] = r2[NQ_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else begin
				dv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			drem_s[k]  <= rem_nx;
			dq_s[k]    <= q_nx;
			dnq_s[k]   <= nq_in;
			dside_s[k] <= side_in;
		end
	end

	// s4: clamp, signed cosine, 1 - c^2
	logic                   v_s4;
	logic [2:0][2*Q_W-1:0]  rad_s4;
	sine_side_t             side_s4;
	logic [2:0][Q_W-1:0]    qc;
	logic [2:0][C_W-1:0]    cs;
	logic [2:0]             cneg;

	assign cneg = {dside_s[Q_W-1].neg_v, dside_s[Q_W-1].neg_p, dside_s[Q_W-1].neg_r};

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			qc[l] = (dq_s[Q_W-1][l] > ONE_Q) ? ONE_Q : dq_s[Q_W-1][l];
			cs[l] = cneg[l] ? -{1'b0, qc[l]} : {1'b0, qc[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= dv_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			rad_s4[l] <= (2*Q_W)'(64'd1 << 32) - (2*Q_W)'(qc[l] * qc[l]);
		end
		side_s4.cr  <= $signed(cs[0]);
		side_s4.cp  <= $signed(cs[1]);
		side_s4.cv  <= $signed(cs[2]);
		side_s4.mx  <= dside_s[Q_W-1].mx;
		side_s4.my  <= dside_s[Q_W-1].my;
		side_s4.mz  <= dside_s[Q_W-1].mz;
		side_s4.inv <= dside_s[Q_W-1].inv;
	end

	// sine roots: s = floor(sqrt(2^32 - c^2))
	logic                 sn_valid;
	logic [2:0][Q_W-1:0]  sn_root;
	sine_side_t           sn_side;

	thac_root #(
		.RW    (Q_W),
		.LANES (3),
		.TAG_W ($bits(sine_side_t))
	) u_sine_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.radicand  (rad_s4),
		.in_tag    (side_s4),
		.out_valid (sn_valid),
		.root      (sn_root),
		.out_tag   (sn_side)
	);

	// s5: first products
	logic                          v_s5, inv_s5;
	logic signed [2*C_W-3:0]       t1_s5, t2_s5, p1_s5, p2_s5, m3_s5;
	logic signed [C_W-1:0]         sr_s5, sp_s5, sv_s5, cr_s5, cp_s5, cv_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= sn_valid;
		end
	end

	always_ff @(posedge clk) begin
		t1_s5  <= sn_side.mx * sn_side.cp;
		t2_s5  <= sn_side.mz * $signed({1'b0, sn_root[1]});
		p1_s5  <= sn_side.mx * $signed({1'b0, sn_root[0]});
		p2_s5  <= sn_side.my * $signed({1'b0, sn_root[0]});
		m3_s5  <= sn_side.my * sn_side.cr;
		sr_s5  <= $signed({1'b0, sn_root[0]});
		sp_s5  <= $signed({1'b0, sn_root[1]});
		sv_s5  <= $signed({1'b0, sn_root[2]});
		cr_s5  <= sn_side.cr;
		cp_s5  <= sn_side.cp;
		cv_s5  <= sn_side.cv;
		inv_s5 <= sn_side.inv;
	end

	// s6: second products and tx
	logic                          v_s6, inv_s6;
	logic signed [CW-1:0]          a_s6, b_s6, tx_s6, m3_s6;
	logic signed [C_W-1:0]         sr_s6, sp_s6, sv_s6, cr_s6, cp_s6, cv_s6;
	logic signed [2*C_W-2:0]       tsum;

	assign tsum = 35'(t1_s5) + 35'(t2_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		a_s6   <= CW'(p1_s5 * sp_s5);
		b_s6   <= CW'(p2_s5 * cp_s5);
		tx_s6  <= CW'(tsum) <<< 16;
		m3_s6  <= CW'(m3_s5) <<< 16;
		sr_s6  <= sr_s5;
		sp_s6  <= sp_s5;
		sv_s6  <= sv_s5;
		cr_s6  <= cr_s5;
		cp_s6  <= cp_s5;
		cv_s6  <= cv_s5;
		inv_s6 <= inv_s5;
	end

	// s7: ty and CORDIC operands
	logic                   v_s7, inv_s7;
	logic [3:0][CW-1:0]     cx_s7, cy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		cx_s7[0] <= CW'(cr_s6) <<< 16;
		cy_s7[0] <= CW'(sr_s6) <<< 16;
		cx_s7[1] <= CW'(cp_s6) <<< 16;
		cy_s7[1] <= CW'(sp_s6) <<< 16;
		cx_s7[2] <= CW'(cv_s6) <<< 16;
		cy_s7[2] <= CW'(sv_s6) <<< 16;
		cx_s7[3] <= tx_s6;
		cy_s7[3] <= a_s6 + m3_s6 - b_s6;
		inv_s7   <= inv_s6;
	end

	// atan2 for the three tilt angles and the heading
	logic               cd_valid;
	logic [3:0][ZW-1:0] cd_angle;
	logic [0:0]         cd_inv;

	thac_cordic #(
		.W      (CW),
		.STAGES (CORDIC_STAGES),
		.LANES  (4),
		.TAG_W  (1)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.x_in      (cx_s7),
		.y_in      (cy_s7),
		.in_tag    (inv_s7),
		.out_valid (cd_valid),
		.angle     (cd_angle),
		.out_tag   (cd_inv)
	);

	// round to output precision, clamp tilt, wrap heading
	logic [2:0][TILT_W-1:0] tilt_fin;
	logic [HEAD_W-1:0]      head_fin;

	always_comb begin
		logic signed [ZW-1:0] r;
		logic signed [ZW-1:0] h;
		for (int l = 0; l < 3; l++) begin
			r = ($signed(cd_angle[l]) + HALF) >>> SH;
			if (r < 0) begin
				r = '0;
			end
			if (r > TOP) begin
				r = TOP;
			end
			tilt_fin[l] = r[TILT_W-1:0];
		end
		h = $signed(cd_angle[3]);
		if (h < 0) begin
			h = h + Z360;
		end
		h = (h + HALF) >>> SH;
		if (h >= FULL) begin
			h = h - FULL;
		end
		if (h < 0) begin
			h = '0;
		end
		head_fin = h[HEAD_W-1:0];
	end

	// s8: result register and strobe
	logic                v_s8, inv_s8;
	logic [TILT_W-1:0]   roll_s8, pitch_s8, vert_s8;
	logic [HEAD_W-1:0]   head_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		inv_s8   <= cd_inv[0];
		roll_s8  <= cd_inv[0] ? '0 : tilt_fin[0];
		pitch_s8 <= cd_inv[0] ? '0 : tilt_fin[1];
		vert_s8  <= cd_inv[0] ? '0 : tilt_fin[2];
		head_s8  <= cd_inv[0] ? '0 : head_fin;
	end

	assign done           = v_s8;
	assign roll_angle     = roll_s8;
	assign pitch_angle    = pitch_s8;
	assign vertical_angle = vert_s8;
	assign heading_angle  = head_s8;
	assign vector_invalid = inv_s8;

endmodule

/* sim/tilt_and_heading_angles_top_tb.sv */
module tilt_and_heading_angles_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import thac_pkg::*;

	localparam int FRAC      = 7;
	localparam int STAGES    = 16;
	localparam int LATENCY   = 75 + STAGES;
	localparam int N_RANDOM  = 1130;
	localparam int TAIL      = 200;
	localparam int STALL_MAX = 5000;
	localparam longint ACC_FRAC = 22;
	localparam longint DEG180   = longint'(180) << ACC_FRAC;
	localparam longint DEG360   = longint'(360) << ACC_FRAC;

	// atan(2^-i) in degrees, 22 fraction bits
	localparam longint ATAN_TAB [24] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	typedef struct {
		logic [TILT_W-1:0] roll;
		logic [TILT_W-1:0] pitch;
		logic [TILT_W-1:0] vert;
		logic [HEAD_W-1:0] heading;
		logic              invalid;
	} angles_t;

	// expected angles per accepted request, checked in order
	class angle_scoreboard;
		angles_t pending_angles[$];
		int      errors;
		int      n_checked;
		int      n_invalid;

		function automatic longint unsigned isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// signed Q16 cosine of one component and its Q16 sine
		function automatic void cos_sin(longint a, longint unsigned nq,
			output longint c, output longint s);
			longint unsigned mag, q;
			mag = (a < 0) ? -a : a;
			q = (mag << 32) / nq;
			if (q > 65536) q = 65536;
			s = longint'(isqrt((64'd1 << 32) - q * q));
			c = (a < 0) ? -longint'(q) : longint'(q);
		endfunction

		// CORDIC vectoring, degrees with 22 fraction bits; >>> floors
		function automatic longint atan2_deg(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				z = (y >= 0) ? DEG180 : -DEG180;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < STAGES && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += ATAN_TAB[i];
				end else begin
					x -= ys; y += xs; z -= ATAN_TAB[i];
				end
			end
			return z;
		endfunction

		function automatic longint to_out(longint z);
			return (z + (longint'(1) << (ACC_FRAC - FRAC - 1))) >>> (ACC_FRAC - FRAC);
		endfunction

		function automatic logic [TILT_W-1:0] tilt(longint s, longint c);
			longint q;
			q = to_out(atan2_deg(s * 65536, c * 65536));
			if (q < 0) q = 0;
			if (q > (longint'(180) << FRAC)) q = longint'(180) << FRAC;
			return q[TILT_W-1:0];
		endfunction

		function automatic void note(logic signed [15:0] ax_i, logic signed [15:0] ay_i,
			logic signed [15:0] az_i, logic signed [15:0] mx_i,
			logic signed [15:0] my_i, logic signed [15:0] mz_i);
			longint ax, ay, az, mx, my, mz, cr, sr, cp, sp, cv, sv, tx, ty, h, hq;
			longint unsigned n2, nq;
			angles_t e;
			ax = ax_i; ay = ay_i; az = az_i;
			mx = mx_i; my = my_i; mz = mz_i;
			n2 = ax * ax + ay * ay + az * az;
			e = '{default: '0};
			if (n2 == 0) begin
				e.invalid = 1'b1;
				pending_angles.push_back(e);
				return;
			end
			nq = isqrt(n2 << 32);
			cos_sin(-ay, nq, cr, sr);
			cos_sin(ax, nq, cp, sp);
			cos_sin(az, nq, cv, sv);
			e.roll  = tilt(sr, cr);
			e.pitch = tilt(sp, cp);
			e.vert  = tilt(sv, cv);
			tx = (mx * cp + mz * sp) * 65536;
			ty = mx * sr * sp + my * cr * 65536 - my * sr * cp;
			h = atan2_deg(ty, tx);
			if (h < 0) h += DEG360;
			hq = to_out(h);
			if (hq >= (longint'(360) << FRAC)) hq -= longint'(360) << FRAC;
			if (hq < 0) hq = 0;
			e.heading = hq[HEAD_W-1:0];
			pending_angles.push_back(e);
		endfunction

		function automatic void check(angles_t got);
			angles_t e;
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected result roll=%0d pitch=%0d vert=%0d head=%0d inv=%0b",
					$time, got.roll, got.pitch, got.vert, got.heading, got.invalid);
				errors++;
				return;
			end
			e = pending_angles.pop_front();
			n_checked++;
			if (e.invalid) n_invalid++;
			if (got.roll !== e.roll) begin
				$display("%0t: roll_angle exp %0d got %0d", $time, e.roll, got.roll);
				errors++;
			end
			if (got.pitch !== e.pitch) begin
				$display("%0t: pitch_angle exp %0d got %0d", $time, e.pitch, got.pitch);
				errors++;
			end
			if (got.vert !== e.vert) begin
				$display("%0t: vertical_angle exp %0d got %0d", $time, e.vert, got.vert);
				errors++;
			end
			if (got.heading !== e.heading) begin
				$display("%0t: heading_angle exp %0d got %0d", $time, e.heading, got.heading);
				errors++;
			end
			if (got.invalid !== e.invalid) begin
				$display("%0t: vector_invalid exp %0b got %0b", $time, e.invalid, got.invalid);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [IN_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [IN_W-1:0] mag_x = '0, mag_y = '0, mag_z = '0;
	logic done;
	logic [TILT_W-1:0] roll_angle, pitch_angle, vertical_angle;
	logic [HEAD_W-1:0] heading_angle;
	logic vector_invalid;

	angle_scoreboard sb = new();
	int n_sent;
	int stall_cycles;

	tilt_and_heading_angles_top #(
		.ANGLE_FRAC_BITS(FRAC),
		.CORDIC_STAGES(STAGES)
	) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// note accepted requests and check strobed results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note(accel_x, accel_y, accel_z, mag_x, mag_y, mag_z);
				n_sent++;
			end
			if (done)
				sb.check('{roll_angle, pitch_angle, vertical_angle, heading_angle,
					vector_invalid});
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (stall_cycles >= STALL_MAX) begin
			$display("[tilt_and_heading_angles_top] ERROR");
			$finish;
		end
	end

	// hold one request until accepted
	task automatic send(input logic [15:0] ax, ay, az, mx, my, mz);
		start   <= 1'b1;
		accel_x <= ax; accel_y <= ay; accel_z <= az;
		mag_x   <= mx; mag_y   <= my; mag_z   <= mz;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_axis(input int mode);
		case (mode)
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(0, 15)) - 16'd8;
			2:       return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom_range(0, 4000)) - 16'd2000;
		endcase
	endfunction

	// random vector: full range, small, extreme, gravity-sized
	task automatic send_random(input bit allow_idle);
		int am, mm;
		logic [15:0] ax, ay, az, mx, my, mz;
		am = $urandom_range(0, 9);
		mm = $urandom_range(0, 9);
		am = (am < 5) ? 0 : (am < 7) ? 3 : (am < 9) ? 1 : 2;
		mm = (mm < 6) ? 0 : (mm < 8) ? 3 : (mm < 9) ? 1 : 2;
		ax = rnd_axis(am); ay = rnd_axis(am); az = rnd_axis(am);
		mx = rnd_axis(mm); my = rnd_axis(mm); mz = rnd_axis(mm);
		// knock out single axes, or a whole vector, now and then
		if ($urandom_range(0, 7) == 0) ax = '0;
		if ($urandom_range(0, 7) == 0) ay = '0;
		if ($urandom_range(0, 7) == 0) az = '0;
		if ($urandom_range(0, 15) == 0) begin
			mx = '0; my = '0; mz = '0;
		end
		if ($urandom_range(0, 63) == 0) begin
			ax = '0; ay = '0; az = '0;
		end
		send(ax, ay, az, mx, my, mz);
		if (allow_idle && $urandom_range(0, 5) == 0)
			idle($urandom_range(1, 14));
	endtask

	initial begin
		n_sent = 0;
		stall_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, single axes both signs, extremes, zero field
		send(16'sd0, 16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'sd300);
		send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send(16'sd1000, 16'sd0, 16'sd0, 16'sd500, 16'sd0, 16'sd0);
		send(-16'sd1000, 16'sd0, 16'sd0, 16'sd500, 16'sd100, 16'sd0);
		send(16'sd0, 16'sd1000, 16'sd0, -16'sd500, 16'sd300, 16'sd20);
		send(16'sd0, -16'sd1000, 16'sd0, 16'sd0, -16'sd700, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd16384, 16'sd300, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd0, -16'sd16384, -16'sd300, 16'sd0, 16'sd0);
		send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send(16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd0, -16'sd1, 16'sd0, -16'sd1, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0, 16'sd0);
		send(16'sd300, -16'sd200, 16'sd900, 16'sd0, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, -16'sd400, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, -16'sd400, -16'sd1, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, -16'sd400, 16'sd1, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, 16'sd400, -16'sd1, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd400, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd1000, 16'sd0, -16'sd400, 16'sd0);

		// drain fully once before going random
		start <= 1'b0;
		while (sb.pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++)
			send_random(i < N_RANDOM - TAIL);

		start <= 1'b0;
		while (sb.pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Sent %0d vectors (%0d zero-acceleration), checked %0d results.",
			n_sent, sb.n_invalid, sb.n_checked);
		$display("Covered axis extremes, single-axis tilts, zero field and random gaps.");
		if (sb.errors == 0 && sb.pending_angles.size() == 0)
			$display("[tilt_and_heading_angles_top] OK");
		else
			$display("[tilt_and_heading_angles_top] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
src/thac_pkg.sv
src/thac_root.sv
src/thac_cordic.sv
src/tilt_and_heading_angles_top.sv
sim/tilt_and_heading_angles_top_tb.sv
